// ===== src/fsd_pkg.sv =====
// Shared types, codes and helpers for the palette dither block.
// No dependencies; fsd_front, fsd_back and the top level import it.
package fsd_pkg;

  localparam int unsigned AddrW = 15;
  localparam int unsigned ErrW  = 10;

  typedef enum logic [1:0] {
    ACT_PIXEL   = 2'd0,
    ACT_PALETTE = 2'd1,
    ACT_TABLE   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_PALETTE,
    ST_ERROR,
    ST_WRITE2
  } state_e;

  typedef struct packed {
    action_e          action;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [AddrW-1:0] address;
    logic [7:0]       table_entry;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [10:0] line_width;
    logic [3:0]  red_shift;
    logic [3:0]  green_shift;
    logic [3:0]  blue_shift;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH  = 2'd0,
    REG_RED_SHIFT   = 2'd1,
    REG_GREEN_SHIFT = 2'd2,
    REG_BLUE_SHIFT  = 2'd3
  } reg_e;

  // Signed divide by 16, truncating toward zero.
  function automatic logic signed [15:0] div16(logic signed [15:0] x);
    logic signed [15:0] t;
    t = x[15] ? (x + 16'sd15) : x;
    return t >>> 4;
  endfunction

  function automatic logic [3:0] sat_shift(logic [3:0] s);
    return (s > 4'd8) ? 4'd8 : s;
  endfunction

endpackage

// ===== src/fsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/fsd_front.sv =====
// Front end: accepts items, drops ignored actions, queues them for the back end.
// Depends on fsd_pkg.
module fsd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  fsd_pkg::item_t item_i,
  output logic          valid_o,
  output fsd_pkg::item_t item_o,
  input  logic          pop_i
);
  import fsd_pkg::*;

  item_t      buf_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rptr_q];
  // drop action 3 at the door: it never reaches the back end
  assign wr      = push && !full && (item_i.action != ACT_NONE);
  assign rd      = pop_i && valid_o;

  always_comb begin
    wptr_d = wr ? ~wptr_q : wptr_q;
    rptr_d = rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== src/fsd_back.sv =====
// Back end: runs loads and the per-pixel dither sequence, queues results.
// Depends on fsd_pkg and fsd_ram.
module fsd_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned INDEX_BITS = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fsd_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  fsd_pkg::item_t item_i,
  output logic           pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     color_index_o,
  output logic           line_end_o
);
  import fsd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = 3 * ErrW;

  state_e st_q, st_d;

  item_t                   px_in_q;
  logic [7:0]              px_q [3];
  logic [7:0]              ci_q;
  logic [CW-1:0]           col_q;
  logic                    first_q;
  logic signed [ErrW-1:0]  right_q [3];
  logic signed [ErrW-1:0]  here_q [3];
  logic signed [ErrW-1:0]  next_q [3];
  logic [CW-1:0]           wr2_addr_q;
  logic [EW-1:0]           wr2_data_q;

  // result queue
  logic [8:0] oq_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       out_push, out_pop, out_full;

  // memories
  logic               err_we;
  logic [CW-1:0]      err_waddr, err_raddr;
  logic [EW-1:0]      err_wdata, err_rdata;
  logic               tab_we;
  logic [INDEX_BITS-1:0] tab_waddr, tab_raddr;
  logic [7:0]         tab_rdata;
  logic               pal_we;
  logic [23:0]        pal_rdata;

  // control
  logic start_pixel, take_load;

  // datapath
  logic [CW:0]            w_eff;
  logic                   last;
  logic [23:0]            addr_wide;
  logic [23:0]            idx_wide;
  logic [7:0]             clamp [3];
  logic signed [11:0]     vsum [3];
  logic [3:0]             rs, gs, bs;
  logic signed [15:0]     e [3];
  logic signed [15:0]     here_new [3];
  logic signed [15:0]     next_new [3];
  logic signed [15:0]     right_new [3];
  logic signed [15:0]     tail_new [3];
  logic [EW-1:0]          here_pack, next_pack;

  fsd_ram #(.WIDTH(EW), .DEPTH(MAX_WIDTH)) u_err (
    .clk_i, .we_i(err_we), .waddr_i(err_waddr), .wdata_i(err_wdata),
    .raddr_i(err_raddr), .rdata_o(err_rdata)
  );
  fsd_ram #(.WIDTH(8), .DEPTH(2 ** INDEX_BITS)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(item_i.table_entry),
    .raddr_i(tab_raddr), .rdata_o(tab_rdata)
  );
  fsd_ram #(.WIDTH(24), .DEPTH(256)) u_pal (
    .clk_i, .we_i(pal_we), .waddr_i(item_i.address[7:0]),
    .wdata_i({item_i.red, item_i.green, item_i.blue}),
    .raddr_i(tab_rdata), .rdata_o(pal_rdata)
  );

  assign out_full = (ocnt_q == 2'd2);
  assign empty    = (ocnt_q == 2'd0);
  assign out_pop  = pop && !empty;
  assign {color_index_o, line_end_o} = oq_q[orp_q];

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (start_pixel) st_d = ST_INDEX;
      ST_INDEX:   st_d = ST_PALETTE;
      ST_PALETTE: st_d = ST_ERROR;
      ST_ERROR:   st_d = (last && col_q != '0) ? ST_WRITE2 : ST_IDLE;
      ST_WRITE2:  st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    start_pixel = 1'b0;
    take_load   = 1'b0;
    out_push    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        take_load   = valid_i && (item_i.action != ACT_PIXEL);
        start_pixel = valid_i && (item_i.action == ACT_PIXEL) && !out_full;
      end
      ST_ERROR: out_push = 1'b1;
      default: ;
    endcase
  end

  assign pop_o     = take_load || start_pixel;
  assign pal_we    = take_load && (item_i.action == ACT_PALETTE);
  assign tab_we    = take_load && (item_i.action == ACT_TABLE);
  assign addr_wide = {{(24 - AddrW){1'b0}}, item_i.address};
  assign tab_waddr = addr_wide[INDEX_BITS-1:0];
  // frame start restarts the column before the error line is read
  assign err_raddr = (start_pixel && item_i.frame_start) ? '0 : col_q;

  always_comb begin
    if (cfg_i.line_width == 11'd0) begin
      w_eff = (CW + 1)'(1);
    end else if (32'(cfg_i.line_width) > MAX_WIDTH) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(cfg_i.line_width);
    end
    last = ({1'b0, col_q} + (CW + 1)'(1)) >= w_eff;
  end

  // add carried errors, clamp, and pack the table index
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [7:0] raw;
      logic signed [ErrW-1:0] below;
      raw = (ch == 0) ? px_in_q.red : ((ch == 1) ? px_in_q.green : px_in_q.blue);
      below = first_q ? '0 : $signed(err_rdata[EW-1-ch*ErrW -: ErrW]);
      vsum[ch] = $signed({4'b0, raw}) + 12'(right_q[ch]) + 12'(below);
      if (vsum[ch] < 0) begin
        clamp[ch] = 8'd0;
      end else if (vsum[ch] > 12'sd255) begin
        clamp[ch] = 8'd255;
      end else begin
        clamp[ch] = vsum[ch][7:0];
      end
    end
    rs = sat_shift(cfg_i.red_shift);
    gs = sat_shift(cfg_i.green_shift);
    bs = sat_shift(cfg_i.blue_shift);
    idx_wide = ({16'b0, clamp[0] >> rs} << (5'd16 - {1'b0, gs} - {1'b0, bs}))
             | ({16'b0, clamp[1] >> gs} << (5'd8 - {1'b0, bs}))
             | {16'b0, clamp[2] >> bs};
    tab_raddr = idx_wide[INDEX_BITS-1:0];
  end

  // form errors and spread them
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      e[ch] = $signed({8'b0, px_q[ch]}) - $signed({8'b0, pal_rdata[23-ch*8 -: 8]});
      here_new[ch]  = 16'(here_q[ch]) + div16(e[ch] * 16'sd3);
      next_new[ch]  = 16'(next_q[ch]) + div16(e[ch] * 16'sd5);
      right_new[ch] = div16(e[ch] * 16'sd7);
      tail_new[ch]  = div16(e[ch]);
      here_pack[EW-1-ch*ErrW -: ErrW] = here_new[ch][ErrW-1:0];
      next_pack[EW-1-ch*ErrW -: ErrW] = next_new[ch][ErrW-1:0];
    end
    err_we    = 1'b0;
    err_waddr = col_q;
    err_wdata = next_pack;
    if (st_q == ST_ERROR) begin
      if (col_q != '0) begin
        err_we    = 1'b1;
        err_waddr = col_q - CW'(1);
        err_wdata = here_pack;
      end else if (last) begin
        err_we = 1'b1;
      end
    end else if (st_q == ST_WRITE2) begin
      err_we    = 1'b1;
      err_waddr = wr2_addr_q;
      err_wdata = wr2_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      col_q   <= '0;
      first_q <= 1'b1;
      owp_q   <= 1'b0;
      orp_q   <= 1'b0;
      ocnt_q  <= 2'd0;
      for (int ch = 0; ch < 3; ch++) begin
        right_q[ch] <= '0;
        here_q[ch]  <= '0;
        next_q[ch]  <= '0;
      end
    end else begin
      st_q <= st_d;
      if (out_push) owp_q <= ~owp_q;
      if (out_pop)  orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + {1'b0, out_push} - {1'b0, out_pop};
      if (start_pixel && item_i.frame_start) begin
        col_q   <= '0;
        first_q <= 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          right_q[ch] <= '0;
          here_q[ch]  <= '0;
          next_q[ch]  <= '0;
        end
      end else if (st_q == ST_ERROR) begin
        if (last) begin
          col_q   <= '0;
          first_q <= 1'b0;
        end else begin
          col_q <= col_q + CW'(1);
        end
        for (int ch = 0; ch < 3; ch++) begin
          right_q[ch] <= last ? '0 : right_new[ch][ErrW-1:0];
          here_q[ch]  <= last ? '0 : next_new[ch][ErrW-1:0];
          next_q[ch]  <= last ? '0 : tail_new[ch][ErrW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_pixel) px_in_q <= item_i;
    if (st_q == ST_INDEX) px_q <= clamp;
    if (st_q == ST_PALETTE) ci_q <= tab_rdata;
    if (st_q == ST_ERROR) begin
      wr2_addr_q <= col_q;
      wr2_data_q <= next_pack;
    end
    if (out_push) oq_q[owp_q] <= {ci_q, last};
  end

endmodule

// ===== src/floyd_steinberg_palette_dither.sv =====
// Top level of the Floyd-Steinberg palette dither block.
// Depends on fsd_pkg, fsd_front, fsd_back (and fsd_ram through fsd_back).
//
// Usage:
//  - Input channel is a queue: drive the item fields and push; the item is
//    taken at a clock edge with push high and full low. Action 1 loads a
//    palette entry, action 2 loads a conversion table entry, action 0 is a
//    pixel in raster order, action 3 is dropped.
//  - Result channel is a queue: while empty is low, color_index_o and
//    line_end_o show the oldest result; pop takes it. Only pixels give one.
//  - Configuration: write cfg_data_i to register cfg_idx_i with cfg_we_i,
//    only while the block is idle (0 line width, 1..3 red/green/blue shift).
//  - Sequencing: a load is taken while the back end is idle. A pixel runs
//    through error line read, table read, palette read, then error update
//    (plus a second error write at the end of a row of two or more pixels),
//    and no new item is taken until it is through; the serial table then
//    palette lookup feeding the next pixel's right-hand error forces this.
//    A pixel's result enters the result queue with its error update.
//  - A two-entry input queue keeps accepting while the back end works; a
//    two-entry result queue holds results while the receiver stalls, and
//    the back end holds a pixel until the result queue has room.
//  - Reset clears the queues, column, carries and registers (width 640,
//    shifts 3); palette, table and error line hold garbage until written.
module floyd_steinberg_palette_dither #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned INDEX_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [14:0] address_i,
  input  logic [7:0]  table_entry_i,
  input  logic        frame_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  color_index_o,
  output logic        line_end_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import fsd_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop;

  // Hold configuration registers; the user must write them only while idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width  <= 11'd640;
      cfg_q.red_shift   <= 4'd3;
      cfg_q.green_shift <= 4'd3;
      cfg_q.blue_shift  <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_LINE_WIDTH:  cfg_q.line_width  <= cfg_data_i;
        REG_RED_SHIFT:   cfg_q.red_shift   <= cfg_data_i[3:0];
        REG_GREEN_SHIFT: cfg_q.green_shift <= cfg_data_i[3:0];
        REG_BLUE_SHIFT:  cfg_q.blue_shift  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{
    action:      action_e'(action_i),
    red:         red_i,
    green:       green_i,
    blue:        blue_i,
    address:     address_i,
    table_entry: table_entry_i,
    frame_start: frame_start_i
  };

  fsd_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .item_i(in_item), .valid_o(q_valid), .item_o(q_item), .pop_i(q_pop)
  );

  fsd_back #(.MAX_WIDTH(MAX_WIDTH), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .valid_i(q_valid), .item_i(q_item), .pop_o(q_pop),
    .empty, .pop, .color_index_o, .line_end_o
  );

endmodule
